// ----- src/cmap_pkg.sv -----
`timescale 1ns / 1ps
// cmap_pkg: shared types and constants of the constellation mapper/demapper
// no dependencies; used by every module of the block but cmap_ram

package cmap_pkg;

  localparam int COORD_W    = 16;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int M_W        = $clog2(MAX_POINTS + 1);
  localparam int SYM_W      = 32;
  localparam int PT_W       = 2 * COORD_W;
  localparam int SQ_W       = 2 * COORD_W;

  // configuration register widths and indexes
  localparam int CFG_NP_W  = 7;
  localparam int CFG_DG_W  = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS     = 2'd1;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_MAP   = 2'd1;
  localparam logic [1:0] REQ_DEMAP = 2'd2;

  // result kinds
  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_DEMAP = 1'b1;

  // divider chain: each cell resolves DIV_STEPS quotient bits
  localparam int DIV_STEPS = 8;
  localparam int DIV_CELLS = SYM_W / DIV_STEPS;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [5:0]                entry_index;
    logic signed [COORD_W-1:0] coord_i;
    logic signed [COORD_W-1:0] coord_q;
    logic [SYM_W-1:0]          symbol_value;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_i;
    logic signed [COORD_W-1:0] out_q;
    logic [5:0]                decided_index;
    logic                      result_kind;
    logic                      last;
  } rsp_t;

  // word handed from one divider cell to the next
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] rem;
    logic [SYM_W-1:0] word;
  } div_stage_t;

  // tag travelling with a table read during a demap scan
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } dm_tag_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] index;
  } dm_res_t;

endpackage

// ----- src/cmap_ram.sv -----
`timescale 1ns / 1ps
// cmap_ram: generic single write port, single read port RAM with registered read
// no dependencies

module cmap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/cmap_div_cell.sv -----
`timescale 1ns / 1ps
// cmap_div_cell: one cell of the restoring divider chain, DIV_STEPS quotient bits
// depends on cmap_pkg

module cmap_div_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [cmap_pkg::M_W-1:0]   divisor,
  input  cmap_pkg::div_stage_t       din,
  output cmap_pkg::div_stage_t       dout
);

  logic [cmap_pkg::IDX_W-1:0] rem_c;
  logic [cmap_pkg::SYM_W-1:0] word_c;
  logic [cmap_pkg::IDX_W:0]   trial;

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_comb begin
    rem_c  = din.rem;
    word_c = din.word;
    trial  = '0;
    for (int k = 0; k < cmap_pkg::DIV_STEPS; k++) begin
      trial  = {rem_c, word_c[cmap_pkg::SYM_W-1]};
      word_c = {word_c[cmap_pkg::SYM_W-2:0], 1'b0};
      if (trial >= divisor) begin
        trial     = trial - divisor;
        word_c[0] = 1'b1;
      end
      rem_c = trial[cmap_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    dout.rem  <= rem_c;
    dout.word <= word_c;
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

endmodule

// ----- src/cmap_dist.sv -----
`timescale 1ns / 1ps
// cmap_dist: squared distance of a sample to each scanned table point, keeps the nearest
// depends on cmap_pkg

module cmap_dist (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [cmap_pkg::COORD_W-1:0] samp_i,
  input  logic signed [cmap_pkg::COORD_W-1:0] samp_q,
  input  cmap_pkg::dm_tag_t                   tag,
  input  logic [cmap_pkg::PT_W-1:0]           point,
  output cmap_pkg::dm_res_t                   res
);

  logic signed [cmap_pkg::COORD_W:0]     di;
  logic signed [cmap_pkg::COORD_W:0]     dq;
  logic signed [2*cmap_pkg::COORD_W+1:0] prod_i;
  logic signed [2*cmap_pkg::COORD_W+1:0] prod_q;
  logic [cmap_pkg::SQ_W-1:0]             sq_i;
  logic [cmap_pkg::SQ_W-1:0]             sq_q;
  cmap_pkg::dm_tag_t                     s1_tag;
  logic [cmap_pkg::SQ_W:0]               dsum;
  logic [cmap_pkg::SQ_W:0]               best_d;

  always_comb begin
    di = {samp_i[cmap_pkg::COORD_W-1], samp_i}
       - {point[cmap_pkg::PT_W-1], point[cmap_pkg::PT_W-1:cmap_pkg::COORD_W]};
    dq = {samp_q[cmap_pkg::COORD_W-1], samp_q}
       - {point[cmap_pkg::COORD_W-1], point[cmap_pkg::COORD_W-1:0]};
    prod_i = di * di;
    prod_q = dq * dq;
  end

  // squares are non-negative and below 2^(2*COORD_W)
  always_ff @(posedge clk) begin
    sq_i <= prod_i[cmap_pkg::SQ_W-1:0];
    sq_q <= prod_q[cmap_pkg::SQ_W-1:0];
    s1_tag.first <= tag.first;
    s1_tag.last  <= tag.last;
    s1_tag.idx   <= tag.idx;
    if (rst) begin
      s1_tag.valid <= 1'b0;
    end else begin
      s1_tag.valid <= tag.valid;
    end
  end

  assign dsum = {1'b0, sq_i} + {1'b0, sq_q};

  // strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (s1_tag.valid && (s1_tag.first || dsum < best_d)) begin
      best_d    <= dsum;
      res.index <= s1_tag.idx;
    end
    if (rst) begin
      res.done <= 1'b0;
    end else begin
      res.done <= s1_tag.valid && s1_tag.last;
    end
  end

endmodule

// ----- src/constellation_map_demap.sv -----
`timescale 1ns / 1ps
// Load word: one table write. Map word: one pass per digit through the divider chain
// and one table read per digit, giving one result word per digit.
// Demap word: a scan of all M points, one table read per cycle on the single RAM read port.
// One word is worked on at a time; a finished result waits in the output register.
// Synchronous active-high reset clears control state and sets num_points 2, digits 1;
// the point table is not cleared and must be loaded before use.

module constellation_map_demap #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cmap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmap_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  cmap_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output cmap_pkg::rsp_t                  rsp
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAP    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DMWAIT = 3'd3;
  localparam logic [2:0] S_DMOUT  = 3'd4;

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic [cmap_pkg::CFG_NP_W-1:0]  num_points;
  logic [cmap_pkg::CFG_DG_W-1:0]  digits;
  logic [cmap_pkg::M_W-1:0]       m_eff;
  logic [CNT_W-1:0]               digits_eff;
  logic                           accept;
  logic                           acc_load;
  logic                           acc_map;
  logic                           acc_demap;

  // divider chain and digit hand-off
  cmap_pkg::div_stage_t           chain [cmap_pkg::DIV_CELLS+1];
  logic                           dig_valid;
  logic [cmap_pkg::IDX_W-1:0]     dig_rem;
  logic [cmap_pkg::SYM_W-1:0]     dig_word;
  logic [CNT_W-1:0]               cnt;
  logic                           dig_last;
  logic                           issue;
  logic                           launch;

  // table read stage
  logic                           rd_valid;
  logic                           rd_last;
  logic                           rd_free;
  logic                           rd_en;
  logic [cmap_pkg::IDX_W-1:0]     rd_addr;
  logic [cmap_pkg::PT_W-1:0]      rd_data;
  logic                           ram_we;

  // demap scan
  logic [cmap_pkg::IDX_W-1:0]     scan_idx;
  logic                           scan_last;
  logic signed [cmap_pkg::COORD_W-1:0] samp_i;
  logic signed [cmap_pkg::COORD_W-1:0] samp_q;
  cmap_pkg::dm_tag_t              dm_tag;
  cmap_pkg::dm_res_t              dm_res;

  logic                           out_free;
  logic                           map_load;
  logic                           dm_load;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= cmap_pkg::CFG_NP_W'(2);
      digits     <= cmap_pkg::CFG_DG_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == cmap_pkg::CFG_NUM_POINTS) begin
        num_points <= cfg_data[cmap_pkg::CFG_NP_W-1:0];
      end else if (cfg_index == cmap_pkg::CFG_DIGITS) begin
        digits <= cfg_data[cmap_pkg::CFG_DG_W-1:0];
      end
    end
  end

  always_comb begin
    if (32'(num_points) < 2) begin
      m_eff = cmap_pkg::M_W'(2);
    end else if (32'(num_points) > cmap_pkg::MAX_POINTS) begin
      m_eff = cmap_pkg::M_W'(cmap_pkg::MAX_POINTS);
    end else begin
      m_eff = cmap_pkg::M_W'(num_points);
    end
    if (digits == '0) begin
      digits_eff = CNT_W'(1);
    end else if (32'(digits) > MAX_DIGITS) begin
      digits_eff = CNT_W'(MAX_DIGITS);
    end else begin
      digits_eff = CNT_W'(digits);
    end
  end

  // input handshake
  assign req_stall = rst || (state != S_IDLE) || rd_valid;
  assign accept    = req_valid && !req_stall;
  assign acc_load  = accept && (req.req_type == cmap_pkg::REQ_LOAD);
  assign acc_map   = accept && (req.req_type == cmap_pkg::REQ_MAP);
  assign acc_demap = accept && (req.req_type == cmap_pkg::REQ_DEMAP);
  assign ram_we    = acc_load && (32'(req.entry_index) < cmap_pkg::MAX_POINTS);

  // map digit flow
  assign out_free = !rsp_valid || !rsp_stall;
  assign map_load = rd_valid && out_free;
  assign rd_free  = !rd_valid || map_load;
  assign dig_last = (cnt == CNT_W'(1));
  assign issue    = (state == S_MAP) && dig_valid && rd_free;
  assign launch   = acc_map || (issue && !dig_last);

  assign chain[0].valid = launch;
  assign chain[0].rem   = '0;
  assign chain[0].word  = acc_map ? req.symbol_value : dig_word;

  for (genvar c = 0; c < cmap_pkg::DIV_CELLS; c++) begin : g_cell
    cmap_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .divisor (m_eff),
      .din     (chain[c]),
      .dout    (chain[c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (chain[cmap_pkg::DIV_CELLS].valid) begin
      dig_rem  <= chain[cmap_pkg::DIV_CELLS].rem;
      dig_word <= chain[cmap_pkg::DIV_CELLS].word;
    end
    if (acc_map) begin
      cnt <= digits_eff;
    end else if (issue && !dig_last) begin
      cnt <= cnt - CNT_W'(1);
    end
    if (rst) begin
      dig_valid <= 1'b0;
    end else if (chain[cmap_pkg::DIV_CELLS].valid) begin
      dig_valid <= 1'b1;
    end else if (issue) begin
      dig_valid <= 1'b0;
    end
  end

  // demap scan, one table read per cycle
  assign scan_last = ({1'b0, scan_idx} == m_eff - cmap_pkg::M_W'(1));

  always_ff @(posedge clk) begin
    if (acc_demap) begin
      samp_i   <= req.coord_i;
      samp_q   <= req.coord_q;
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + cmap_pkg::IDX_W'(1);
    end
    dm_tag.first <= (scan_idx == '0);
    dm_tag.last  <= scan_last;
    dm_tag.idx   <= scan_idx;
    if (rst) begin
      dm_tag.valid <= 1'b0;
    end else begin
      dm_tag.valid <= (state == S_SCAN);
    end
  end

  // table memory
  assign rd_en   = issue || (state == S_SCAN);
  assign rd_addr = issue ? dig_rem : scan_idx;

  cmap_ram #(
    .WIDTH (cmap_pkg::PT_W),
    .DEPTH (cmap_pkg::MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.entry_index[cmap_pkg::IDX_W-1:0]),
    .wdata ({req.coord_i, req.coord_q}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // read data holds until taken, as the read enable stays low meanwhile
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last <= dig_last;
    end
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (issue) begin
      rd_valid <= 1'b1;
    end else if (map_load) begin
      rd_valid <= 1'b0;
    end
  end

  cmap_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .samp_i (samp_i),
    .samp_q (samp_q),
    .tag    (dm_tag),
    .point  (rd_data),
    .res    (dm_res)
  );

  // control
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc_map) begin
          state_next = S_MAP;
        end else if (acc_demap) begin
          state_next = S_SCAN;
        end
      end
      S_MAP: begin
        if (issue && dig_last) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DMWAIT;
        end
      end
      S_DMWAIT: begin
        if (dm_res.done) begin
          state_next = S_DMOUT;
        end
      end
      S_DMOUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  assign dm_load = (state == S_DMOUT) && out_free;

  always_ff @(posedge clk) begin
    if (map_load) begin
      rsp.out_i         <= rd_data[cmap_pkg::PT_W-1:cmap_pkg::COORD_W];
      rsp.out_q         <= rd_data[cmap_pkg::COORD_W-1:0];
      rsp.decided_index <= '0;
      rsp.result_kind   <= cmap_pkg::KIND_MAP;
      rsp.last          <= rd_last;
    end else if (dm_load) begin
      rsp.out_i         <= '0;
      rsp.out_q         <= '0;
      rsp.decided_index <= 6'(dm_res.index);
      rsp.result_kind   <= cmap_pkg::KIND_DEMAP;
      rsp.last          <= 1'b1;
    end
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (map_load || dm_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// ----- src/cmap_checker.sv -----
`timescale 1ns / 1ps
// cmap_checker: port-level checks of constellation_map_demap, bound to the top level
// depends on cmap_pkg and constellation_map_demap

module cmap_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input cmap_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input cmap_pkg::rsp_t rsp
);

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // map and demap words occupy the block, so the next word is held off
  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall &&
    (req.req_type == cmap_pkg::REQ_MAP || req.req_type == cmap_pkg::REQ_DEMAP)
    |=> req_stall)
    else $error("input not stalled after a map or demap word");

  // a demap decision is a single word with zero coordinates
  a_demap_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind == cmap_pkg::KIND_DEMAP
    |-> rsp.last && rsp.out_i == '0 && rsp.out_q == '0)
    else $error("malformed demap result");

  a_map_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind == cmap_pkg::KIND_MAP |-> rsp.decided_index == '0)
    else $error("map result carries a decided index");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid straight after reset");

endmodule

bind constellation_map_demap cmap_checker u_cmap_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
